### rtl/kse_pkg.sv
package kse_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODES_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODES_1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CODES_2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CODES_3  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT  = 3'd5;

  typedef enum logic [1:0] {
    MODE_CHAR = 2'd0,
    MODE_BYTE = 2'd1,
    MODE_WORD = 2'd2,
    MODE_DEC  = 2'd3
  } entry_mode_t;

  // default table "0123456789ABCDEF", index i in byte i%4 of word i/4
  localparam logic [3:0][31:0] CODES_RST = '{
    32'h4645_4443, 32'h4241_3938, 32'h3736_3534, 32'h3332_3130
  };

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UPPER = 8'h41;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;

  typedef struct packed {
    logic       hit;
    logic [1:0] pos;
  } line_dec_t;

  // single low line in an active-low nibble
  function automatic line_dec_t line_pos(input logic [3:0] nib);
    line_dec_t d;
    d = '{hit: 1'b1, pos: 2'd0};
    case (nib)
      4'h7:    d.pos = 2'd3;
      4'hB:    d.pos = 2'd2;
      4'hD:    d.pos = 2'd1;
      4'hE:    d.pos = 2'd0;
      default: d.hit = 1'b0;
    endcase
    return d;
  endfunction

  // hex digit value, no range check, 8-bit wrap
  function automatic logic [7:0] hex_val(input logic [7:0] c);
    return (c >= CHAR_UPPER) ? (c - HEX_ALPHA_OFS) : (c - CHAR_ZERO);
  endfunction

endpackage

### rtl/kse_ifs.sv
interface kse_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] row_lines;
  logic [3:0] col_lines;

  modport source (output valid, output row_lines, output col_lines, input ready);
  modport sink   (input valid, input row_lines, input col_lines, output ready);
endinterface

interface kse_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] entry_value;
  logic [1:0]  entry_kind;
  logic [7:0]  last_key;

  modport source (output valid, output entry_value, output entry_kind, output last_key,
                  input ready);
  modport sink   (input valid, input entry_value, input entry_kind, input last_key,
                  output ready);
endinterface

### rtl/keypad_scan_entry_unit.sv
// channel  | dir | payload                                  | handshake
// in_if    | in  | row_lines[3:0], col_lines[3:0]           | valid/ready
// out_if   | out | entry_value[15:0], entry_kind[1:0],      | valid/ready
//          |     | last_key[7:0]                            |
// cfg      | in  | cfg_index[2:0], cfg_data[31:0]           | cfg_we, no wait
//
// one scan sample per clock while not stalled: a beat lands in the input register,
// then decode, table select and entry update load the result register as the stage advances
// a beat passes the input register and then the result register; zero or one result per beat
// while a result waits the input register still takes one more beat, then input
// stalls; the pipe stalls only when a result is held and not taken
// rst_n is synchronous, active low; it restores the default table and mode
module keypad_scan_entry_unit import kse_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  kse_in_if.sink                in_if,
  kse_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    PH_PRESS   = 2'd0,
    PH_RELEASE = 2'd1,
    PH_LOCK    = 2'd2
  } phase_t;

  // configuration registers
  entry_mode_t      mode_r;
  logic [3:0][31:0] codes_r;
  logic [15:0]      lock_ticks_r;

  // input register
  logic       in_vld_r;
  logic [3:0] row_r;
  logic [3:0] col_r;

  // scan state
  phase_t      phase_r,    phase_nxt;
  logic [7:0]  held_r,     held_nxt;
  logic [15:0] lock_cnt_r, lock_cnt_nxt;
  logic [15:0] acc_r,      acc_nxt;
  logic [1:0]  dcnt_r,     dcnt_nxt;

  // result register
  logic        out_vld_r,  out_vld_nxt;
  logic [15:0] value_r;
  logic [1:0]  kind_r;
  logic [7:0]  key_r;

  logic        advance;
  line_dec_t   row_dec, col_dec;
  logic        hit;
  logic [3:0]  key_idx;
  logic [31:0] code_word;
  logic [7:0]  code;

  logic        take;        // a held key is accepted this beat
  logic        done;        // an entry completes this beat
  logic [15:0] res_val;
  logic [7:0]  digit;
  logic [7:0]  dec_digit;
  logic [7:0]  lo_byte;

  // the stage moves when the input register holds a beat and the result slot is free or being emptied
  assign advance      = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready  = !in_vld_r || advance;

  assign out_if.valid       = out_vld_r;
  assign out_if.entry_value = value_r;
  assign out_if.entry_kind  = kind_r;
  assign out_if.last_key    = key_r;

  // key decode and code table select
  always_comb begin
    row_dec   = line_pos(row_r);
    col_dec   = line_pos(col_r);
    hit       = row_dec.hit && col_dec.hit;
    key_idx   = {row_dec.pos, col_dec.pos};
    code_word = codes_r[key_idx[3:2]];
    code      = hit ? code_word[{key_idx[1:0], 3'b000} +: 8] : 8'h00;
  end

  // press / release / lockout sequence
  always_comb begin
    phase_nxt    = phase_r;
    held_nxt     = held_r;
    lock_cnt_nxt = lock_cnt_r;
    take         = 1'b0;
    unique case (phase_r)
      PH_RELEASE: begin
        if (!hit) begin
          if (lock_ticks_r == 16'd0) begin
            phase_nxt = PH_PRESS;
            take      = 1'b1;
          end else begin
            lock_cnt_nxt = lock_ticks_r;
            phase_nxt    = PH_LOCK;
          end
        end
      end
      PH_LOCK: begin
        // scan lines are ignored while locked out
        if (lock_cnt_r <= 16'd1) begin
          lock_cnt_nxt = 16'd0;
          phase_nxt    = PH_PRESS;
          take         = 1'b1;
        end else begin
          lock_cnt_nxt = lock_cnt_r - 16'd1;
        end
      end
      default: begin
        // waiting for press; the spare code behaves the same
        phase_nxt = PH_PRESS;
        if (code != 8'h00) begin
          held_nxt  = code;
          phase_nxt = PH_RELEASE;
        end
      end
    endcase
  end

  // entry assembly for an accepted key
  always_comb begin
    digit     = hex_val(held_r);
    dec_digit = held_r - CHAR_ZERO;
    lo_byte   = {acc_r[3:0], 4'h0} + digit;
    acc_nxt   = acc_r;
    dcnt_nxt  = dcnt_r;
    done      = 1'b0;
    res_val   = 16'd0;
    if (take) begin
      case (mode_r)
        MODE_CHAR: begin
          res_val = {8'h00, held_r};
          done    = 1'b1;
        end
        MODE_BYTE: begin
          if (dcnt_r == 2'd0) begin
            acc_nxt  = {8'h00, digit};
            dcnt_nxt = 2'd1;
          end else begin
            res_val  = {8'h00, lo_byte};
            acc_nxt  = 16'd0;
            dcnt_nxt = 2'd0;
            done     = 1'b1;
          end
        end
        MODE_WORD: begin
          case (dcnt_r)
            2'd0:    acc_nxt = {8'h00, digit};
            2'd1:    acc_nxt = {8'h00, lo_byte};
            2'd2:    acc_nxt = {acc_r[7:0], 8'h00} | {8'h00, digit};
            default: begin
              res_val = {acc_r[15:8], lo_byte};
              acc_nxt = 16'd0;
              done    = 1'b1;
            end
          endcase
          dcnt_nxt = dcnt_r + 2'd1;
        end
        default: begin
          // decimal: times ten plus digit, a non-digit ends the number
          if (held_r >= CHAR_ZERO && held_r <= CHAR_NINE) begin
            acc_nxt = {acc_r[12:0], 3'b000} + {acc_r[14:0], 1'b0} + {8'h00, dec_digit};
          end else begin
            res_val  = acc_r;
            acc_nxt  = 16'd0;
            dcnt_nxt = 2'd0;
            done     = 1'b1;
          end
        end
      endcase
    end
  end

  // result slot: loads on a completed entry, empties when taken
  assign out_vld_nxt = advance ? done : (out_vld_r && !out_if.ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_CHAR;
      codes_r      <= CODES_RST;
      lock_ticks_r <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:    mode_r       <= entry_mode_t'(cfg_data[1:0]);
        CFG_CODES_0: codes_r[0]   <= cfg_data;
        CFG_CODES_1: codes_r[1]   <= cfg_data;
        CFG_CODES_2: codes_r[2]   <= cfg_data;
        CFG_CODES_3: codes_r[3]   <= cfg_data;
        CFG_LOCKOUT: lock_ticks_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      row_r <= in_if.row_lines;
      col_r <= in_if.col_lines;
    end
  end

  // scan state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_PRESS;
      held_r     <= 8'h00;
      lock_cnt_r <= 16'd0;
      acc_r      <= 16'd0;
      dcnt_r     <= 2'd0;
      out_vld_r  <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (cfg_we && cfg_index == CFG_MODE) begin
        // a mode change drops any partial entry
        acc_r  <= 16'd0;
        dcnt_r <= 2'd0;
      end else if (advance) begin
        acc_r  <= acc_nxt;
        dcnt_r <= dcnt_nxt;
      end
      if (advance) begin
        phase_r    <= phase_nxt;
        held_r     <= held_nxt;
        lock_cnt_r <= lock_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && done) begin
      value_r <= res_val;
      kind_r  <= mode_r;
      key_r   <= held_r;
    end
  end

endmodule

### rtl/kse_checker.sv
module kse_checker import kse_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] entry_value,
  input logic [1:0]  entry_kind,
  input logic [7:0]  last_key
);

  // a held result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a held result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(entry_value) && $stable(entry_kind)
                                && $stable(last_key))
    else $error("result payload changed while stalled");

  // reset empties the result slot
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a single-char entry carries the key itself
  a_char_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && entry_kind == MODE_CHAR |->
      entry_value[15:8] == 8'h00 && entry_value[7:0] == last_key)
    else $error("single char value does not match key");

  // a hex byte entry fits in eight bits
  a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && entry_kind == MODE_BYTE |-> entry_value[15:8] == 8'h00)
    else $error("hex byte value wider than a byte");

endmodule

bind keypad_scan_entry_unit kse_checker u_kse_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .entry_value (out_if.entry_value),
  .entry_kind  (out_if.entry_kind),
  .last_key    (out_if.last_key)
);

### bench/tb_keypad_scan_entry_unit.sv
module tb_keypad_scan_entry_unit import kse_pkg::*;;

  // cycles with no beat on either channel before the run is called hung
  localparam int STALL_LIMIT  = 1000;
  // scan beats wanted from the randomized part, lockout filler included
  localparam int RANDOM_BEATS = 950;
  localparam int MAX_SHOWN    = 10;
  // pipe depth is two; a little margin before touching registers or ending
  localparam int DRAIN_CYCLES = 4;

  // scanner phases as the block walks through a key stroke
  typedef enum logic [1:0] {
    SCAN_PRESS   = 2'd0,
    SCAN_RELEASE = 2'd1,
    SCAN_LOCKOUT = 2'd2,
    SCAN_SPARE   = 2'd3
  } scan_phase_t;

  // one completed entry as it should leave the block
  typedef struct packed {
    logic [15:0] value;
    entry_mode_t kind;
    logic [7:0]  key;
  } entry_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  kse_in_if  in_if ();
  kse_out_if out_if ();

  keypad_scan_entry_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // scanner model: register copies and walking state
  // ---------------------------------------------------------------------
  entry_mode_t  entry_mode_q;
  logic [7:0]   key_table [16];
  logic [15:0]  lock_len;

  scan_phase_t  scan_phase;
  logic [7:0]   held_char;
  logic [15:0]  lock_cnt;
  logic [15:0]  entry_acc;
  logic [1:0]   entry_digits;

  // entries predicted and not yet seen on the result channel
  entry_t       pending_entries [$];

  // bookkeeping
  int error_count;
  int entries_checked;
  int total_beats;
  int live_beats;
  int settings_run;

  // stall shaping, both sides
  bit in_calm;
  bit out_calm;
  int ready_left;
  int ready_roll;
  int quiet_cycles;

  // default character for a key: digits then upper-case hex letters
  function automatic logic [7:0] default_char(input int idx);
    return (idx < 10) ? 8'(8'h30 + idx) : 8'(8'h37 + idx);
  endfunction

  function automatic logic [31:0] default_word(input int k);
    logic [31:0] w;
    for (int b = 0; b < 4; b++) w[8*b +: 8] = default_char(4*k + b);
    return w;
  endfunction

  task automatic preset_model();
    entry_mode_q = MODE_CHAR;
    for (int i = 0; i < 16; i++) key_table[i] = default_char(i);
    lock_len     = '0;
    scan_phase   = SCAN_PRESS;
    held_char    = '0;
    lock_cnt     = '0;
    entry_acc    = '0;
    entry_digits = '0;
  endtask

  // which line is pulled low, -1 when zero or several are
  function automatic int low_line(input logic [3:0] nib);
    case (nib)
      4'h7:    return 3;
      4'hB:    return 2;
      4'hD:    return 1;
      4'hE:    return 0;
      default: return -1;
    endcase
  endfunction

  // nibble value of a character, letters from 'A' up, no range check
  function automatic logic [7:0] nibble_of(input logic [7:0] c);
    return (c >= CHAR_UPPER) ? 8'(c - HEX_ALPHA_OFS) : 8'(c - CHAR_ZERO);
  endfunction

  // fold an accepted character into the entry in progress
  function automatic bit take_char(input logic [7:0] c, output entry_t done_entry);
    logic [7:0] d;
    logic [7:0] low_byte;
    bit         done;
    d          = nibble_of(c);
    done       = 1'b0;
    done_entry = '{value: 16'h0, kind: entry_mode_q, key: c};
    case (entry_mode_q)
      MODE_CHAR: begin
        done_entry.value = {8'h00, c};
        done = 1'b1;
      end
      MODE_BYTE: begin
        if (entry_digits == 2'd0) begin
          entry_acc    = {8'h00, d};
          entry_digits = 2'd1;
        end else begin
          low_byte         = (entry_acc[7:0] << 4) + d;
          done_entry.value = {8'h00, low_byte};
          entry_acc        = '0;
          entry_digits     = '0;
          done = 1'b1;
        end
      end
      MODE_WORD: begin
        // high byte builds in the low half, then moves up on the third digit
        case (entry_digits)
          2'd0: entry_acc = {8'h00, d};
          2'd1: begin
            low_byte  = (entry_acc[7:0] << 4) + d;
            entry_acc = {8'h00, low_byte};
          end
          2'd2: entry_acc = {entry_acc[7:0], d};
          default: begin
            low_byte         = (entry_acc[7:0] << 4) + d;
            done_entry.value = {entry_acc[15:8], low_byte};
            entry_acc        = '0;
            done = 1'b1;
          end
        endcase
        entry_digits = entry_digits + 2'd1;
      end
      default: begin
        // decimal: digits accumulate with 16-bit wrap, anything else ends it
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
          entry_acc = entry_acc * 16'd10 + 16'(c - CHAR_ZERO);
        end else begin
          done_entry.value = entry_acc;
          entry_acc        = '0;
          entry_digits     = '0;
          done = 1'b1;
        end
      end
    endcase
    return done;
  endfunction

  // one scan beat through the model; returns whether an entry completes
  function automatic bit scan_step(input logic [3:0] rows, input logic [3:0] cols,
                                   output entry_t done_entry);
    int         r;
    int         c;
    bit         hit;
    logic [7:0] ch;
    r          = low_line(rows);
    c          = low_line(cols);
    hit        = (r >= 0) && (c >= 0);
    ch         = '0;
    done_entry = '0;
    if (hit) ch = key_table[4*r + c];
    case (scan_phase)
      SCAN_RELEASE: begin
        // any decoded key still counts as held, whatever its character
        if (!hit) begin
          if (lock_len == 16'd0) begin
            scan_phase = SCAN_PRESS;
            return take_char(held_char, done_entry);
          end
          lock_cnt   = lock_len;
          scan_phase = SCAN_LOCKOUT;
        end
        return 1'b0;
      end
      SCAN_LOCKOUT: begin
        // lines are ignored while counting down
        if (lock_cnt <= 16'd1) begin
          lock_cnt   = '0;
          scan_phase = SCAN_PRESS;
          return take_char(held_char, done_entry);
        end
        lock_cnt = lock_cnt - 16'd1;
        return 1'b0;
      end
      default: begin
        // a zero character is no key at all
        scan_phase = SCAN_PRESS;
        if (ch != 8'h00) begin
          held_char  = ch;
          scan_phase = SCAN_RELEASE;
        end
        return 1'b0;
      end
    endcase
  endfunction

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    case (idx)
      CFG_MODE: begin
        // a mode write drops any half-built entry
        entry_mode_q = entry_mode_t'(data[1:0]);
        entry_acc    = '0;
        entry_digits = '0;
      end
      CFG_CODES_0, CFG_CODES_1, CFG_CODES_2, CFG_CODES_3: begin
        for (int b = 0; b < 4; b++) key_table[(idx - CFG_CODES_0) * 4 + b] = data[8*b +: 8];
      end
      CFG_LOCKOUT: lock_len = data[15:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // mostly back to back, sometimes short holes, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // active-low nibble with just one line pulled
  function automatic logic [3:0] line_code(input int pos);
    return 4'hF ^ (4'h1 << pos);
  endfunction

  // nibble that decodes to no line: none, several or all low
  function automatic logic [3:0] noise_nibble();
    logic [3:0] n;
    do n = 4'($urandom_range(0, 15)); while (low_line(n) >= 0);
    return n;
  endfunction

  // one beat on the scan channel; live marks beats that are not lockout filler
  task automatic send_scan(input logic [3:0] rows, input logic [3:0] cols, input bit live);
    int     gap;
    entry_t done_entry;
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.row_lines <= rows;
    in_if.col_lines <= cols;
    do @(posedge clk); while (!in_if.ready);
    if (scan_step(rows, cols, done_entry)) pending_entries.push_back(done_entry);
    total_beats++;
    if (live) live_beats++;
  endtask

  task automatic press_key(input int idx);
    send_scan(line_code(idx / 4), line_code(idx % 4), 1'b1);
  endtask

  // release beat: one or both nibbles stop decoding
  task automatic lift_keys();
    case ($urandom_range(0, 2))
      0:       send_scan(noise_nibble(), noise_nibble(), 1'b1);
      1:       send_scan(noise_nibble(), line_code($urandom_range(0, 3)), 1'b1);
      default: send_scan(line_code($urandom_range(0, 3)), noise_nibble(), 1'b1);
    endcase
  endtask

  // full key stroke: press (maybe bouncing over other keys), release, lockout
  task automatic enter_key(input int idx, input bit bouncy);
    int presses;
    presses = bouncy ? $urandom_range(1, 3) : 1;
    for (int p = 0; p < presses; p++) begin
      if (p > 0 && $urandom_range(0, 2) == 0) press_key($urandom_range(0, 15));
      else press_key(idx);
    end
    lift_keys();
    // anything goes while the block counts down
    while (scan_phase == SCAN_LOCKOUT) send_scan(4'($urandom), 4'($urandom), 1'b0);
  endtask

  // stop sending, let every entry drain, then cover the pipe depth
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write: one cycle of cfg_we, only ever called after settle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic load_default_table();
    for (int k = 0; k < 4; k++) write_reg(CFG_CODES_0 + 3'(k), default_word(k));
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // out of reset: single characters, default table, no lockout
  task automatic test_reset_chars();
    // two corner keys, a middle digit and a letter
    enter_key(0, 1'b0);
    enter_key(15, 1'b0);
    enter_key(6, 1'b0);
    enter_key(10, 1'b0);
    // no line, all lines, and one side only: none of these is a press
    send_scan(4'h0, line_code(0), 1'b1);
    send_scan(4'hF, line_code(3), 1'b1);
    send_scan(line_code(3), 4'h0, 1'b1);
    send_scan(line_code(0), 4'hF, 1'b1);
    // held key slides to another one; the first character wins
    press_key(3);
    press_key(12);
    send_scan(line_code(1), 4'h3, 1'b1);
    settle();
  endtask

  // every table register, zero characters and all-ones characters
  task automatic test_code_table();
    write_reg(CFG_CODES_0, 32'hFF00_5A01);
    write_reg(CFG_CODES_1, 32'h0000_0000);
    write_reg(CFG_CODES_2, 32'hFFFF_FFFF);
    write_reg(CFG_CODES_3, 32'h8041_3A2F);
    settings_run++;
    enter_key(0, 1'b0);
    enter_key(3, 1'b0);
    // zero characters (keys 2 and 5) never arm the scanner
    enter_key(2, 1'b0);
    enter_key(5, 1'b0);
    enter_key(8, 1'b0);
    enter_key(12, 1'b0);
    settle();
    // odd characters folded as hex digits
    write_reg(CFG_MODE, 32'(MODE_BYTE));
    enter_key(3, 1'b0);
    enter_key(15, 1'b0);
    settle();
    // characters just outside the digit range end a decimal number
    write_reg(CFG_MODE, 32'(MODE_DEC));
    enter_key(0, 1'b0);
    enter_key(12, 1'b0);
    enter_key(13, 1'b0);
    settle();
    load_default_table();
  endtask

  task automatic test_hex_entry();
    write_reg(CFG_MODE, 32'(MODE_BYTE));
    settings_run++;
    enter_key(1, 1'b0);
    enter_key(15, 1'b0);
    enter_key(10, 1'b0);
    enter_key(0, 1'b0);
    settle();
    write_reg(CFG_MODE, 32'(MODE_WORD));
    settings_run++;
    enter_key(11, 1'b0);
    enter_key(14, 1'b0);
    enter_key(14, 1'b0);
    enter_key(15, 1'b0);
    // one digit of a new word, then a mode write throws it away
    enter_key(11, 1'b0);
    settle();
    write_reg(CFG_MODE, 32'(MODE_WORD));
    for (int k = 1; k <= 4; k++) enter_key(k, 1'b0);
    settle();
  endtask

  task automatic test_decimal();
    write_reg(CFG_MODE, 32'(MODE_DEC));
    settings_run++;
    enter_key(1, 1'b0);
    enter_key(2, 1'b0);
    enter_key(3, 1'b0);
    enter_key(10, 1'b0);
    // terminator alone reports zero
    enter_key(12, 1'b0);
    // six nines wrap past 16 bits
    repeat (6) enter_key(9, 1'b0);
    enter_key(11, 1'b0);
    // digits dropped by a mode write
    enter_key(7, 1'b0);
    settle();
    write_reg(CFG_MODE, 32'(MODE_DEC));
    enter_key(15, 1'b0);
    settle();
  endtask

  task automatic test_lockout();
    write_reg(CFG_MODE, 32'(MODE_CHAR));
    write_reg(CFG_LOCKOUT, 32'd1);
    settings_run++;
    enter_key(4, 1'b1);
    enter_key(13, 1'b1);
    settle();
    write_reg(CFG_LOCKOUT, 32'd3);
    settings_run++;
    enter_key(8, 1'b1);
    enter_key(2, 1'b1);
    settle();
    // long lockout, run at full rate to keep it short
    write_reg(CFG_LOCKOUT, 32'd100);
    settings_run++;
    in_calm  = 1'b1;
    out_calm = 1'b1;
    enter_key(7, 1'b0);
    enter_key(14, 1'b0);
    settle();
    in_calm  = 1'b0;
    out_calm = 1'b0;
    write_reg(CFG_LOCKOUT, 32'd0);
  endtask

  // table byte: mostly hex characters, some arbitrary, some empty keys
  function automatic logic [7:0] random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return default_char($urandom_range(0, 15));
    if (r < 90) return 8'($urandom);
    return 8'h00;
  endfunction

  function automatic int pick_key();
    if (entry_mode_q == MODE_DEC && $urandom_range(0, 9) < 7) return $urandom_range(0, 9);
    return $urandom_range(0, 15);
  endfunction

  task automatic random_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      enter_key(pick_key(), 1'b1);
    end else if (r < 90) begin
      // raw lines, may or may not be a key
      send_scan(4'($urandom), 4'($urandom), 1'b1);
    end else begin
      // stroke abandoned into garbage
      press_key($urandom_range(0, 15));
      send_scan(4'($urandom), 4'($urandom), 1'b1);
    end
  endtask

  task automatic test_random_entry();
    int         start_beats;
    int         r;
    logic [31:0] w;
    start_beats = total_beats;
    while (total_beats - start_beats < RANDOM_BEATS) begin
      settle();
      if ($urandom_range(0, 1) == 0) begin
        for (int k = 0; k < 4; k++) begin
          for (int b = 0; b < 4; b++) w[8*b +: 8] = random_char();
          write_reg(CFG_CODES_0 + 3'(k), w);
        end
      end else begin
        load_default_table();
      end
      r = $urandom_range(0, 99);
      if (r < 55)      write_reg(CFG_LOCKOUT, 32'd0);
      else if (r < 85) write_reg(CFG_LOCKOUT, $urandom_range(1, 4));
      else             write_reg(CFG_LOCKOUT, $urandom_range(5, 30));
      write_reg(CFG_MODE, 32'($urandom_range(0, 3)));
      settings_run++;
      // some settings run with one or both sides flat out
      in_calm  = ($urandom_range(0, 4) == 0);
      out_calm = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(40, 80))
        if (total_beats - start_beats < RANDOM_BEATS) random_action();
    end
    in_calm  = 1'b0;
    out_calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------
  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_if.valid     = 1'b0;
    in_if.row_lines = 4'hF;
    in_if.col_lines = 4'hF;
    out_if.ready    = 1'b0;
    in_calm         = 1'b0;
    out_calm        = 1'b0;
    ready_left      = 0;
    quiet_cycles    = 0;
    error_count     = 0;
    entries_checked = 0;
    total_beats     = 0;
    live_beats      = 0;
    settings_run    = 1;
    preset_model();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_chars();
    test_code_table();
    test_hex_entry();
    test_decimal();
    test_lockout();
    test_random_entry();
    settle();

    $display("covered %0d scan beats (%0d outside lockout) over %0d register settings",
             total_beats, live_beats, settings_run);
    $display("checked %0d entries in char, hex byte, hex word and decimal modes",
             entries_checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // result side: random back-pressure and entry checking
  // ---------------------------------------------------------------------

  // ready mostly high in runs, short dips, rare long stalls
  always @(posedge clk) begin
    if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if (out_calm) begin
      out_if.ready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 60) begin
        out_if.ready <= 1'b1;
        ready_left   <= $urandom_range(0, 15);
      end else if (ready_roll < 92) begin
        out_if.ready <= 1'b0;
        ready_left   <= $urandom_range(0, 3);
      end else begin
        out_if.ready <= 1'b0;
        ready_left   <= $urandom_range(10, 40);
      end
    end
  end

  entry_t want;

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      entries_checked++;
      if (pending_entries.size() == 0) begin
        error_count++;
        if (error_count <= MAX_SHOWN)
          $display("entry beat with nothing pending: value %h kind %0d key %h",
                   out_if.entry_value, out_if.entry_kind, out_if.last_key);
      end else begin
        want = pending_entries.pop_front();
        if (out_if.entry_value !== want.value || out_if.entry_kind !== want.kind ||
            out_if.last_key !== want.key) begin
          error_count++;
          if (error_count <= MAX_SHOWN)
            $display("entry mismatch: expected value %h kind %0d key %h, got %h %0d %h",
                     want.value, want.kind, want.key,
                     out_if.entry_value, out_if.entry_kind, out_if.last_key);
        end
      end
    end
  end

  // hang detection: no beat on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no beat for %0d cycles, %0d entries still pending",
               quiet_cycles, pending_entries.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

### sim.f
rtl/kse_pkg.sv
rtl/kse_ifs.sv
rtl/keypad_scan_entry_unit.sv
rtl/kse_checker.sv
bench/tb_keypad_scan_entry_unit.sv
